[rtl/kpe_pkg.sv]
// Shared types, constants and codes for the k-core peeling engine.
`timescale 1ns / 1ps
`default_nettype none
package kpe_pkg;
  localparam int MaxVertices  = 1024;
  localparam int MaxEdgeSlots = 8192;
  localparam int VW = $clog2(MaxVertices);       // vertex id bits
  localparam int CW = VW + 1;                    // count bits
  localparam int EW = $clog2(MaxEdgeSlots);      // edge slot bits
  localparam int OW = EW + 1;                    // offset bits
  localparam int DW = 10;                        // degree / core bits
  localparam int OpW = 2;
  localparam int IdxW = 13;
  localparam int ValW = 14;
  localparam logic [DW-1:0] CoreLimit = {DW{1'b1}};

  localparam logic [OpW-1:0] OP_LOAD_OFS = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_NBR = 2'd1;
  localparam logic [OpW-1:0] OP_RUN      = 2'd2;
  localparam logic [OpW-1:0] OP_READ     = 2'd3;

  // Result kinds
  localparam logic KIND_CORE = 1'b0;   // core number of one vertex
  localparam logic KIND_RUN  = 1'b1;   // maximum core after a run

  // Commands from controller to datapath
  typedef struct packed {
    logic [VW:0]   ofs_addr;
    logic [EW-1:0] nbr_addr;
    logic [VW-1:0] deg_addr;
    logic          deg_wr;
    logic [VW-1:0] deg_wr_addr;
    logic [DW-1:0] deg_wr_data;
    logic          q_wr;
    logic [VW-1:0] q_wr_addr;
    logic [VW-1:0] q_wr_data;
    logic [VW-1:0] q_rd_addr;
  } kpe_cmd_t;

  // Registered read data back to controller
  typedef struct packed {
    logic [OW-1:0]   ofs_q;      // clamped offset
    logic [ValW-1:0] nbr_q;
    logic [DW-1:0]   deg_q;
    logic [VW-1:0]   q_q;
  } kpe_sts_t;
endpackage
`default_nettype wire

[rtl/kcore_peeling_engine_top.sv]
// Top level of the k-core peeling engine.
// Load items stream back to back while the engine is not busy.
// A read result follows its degree read; the next item is accepted once the result leaves.
// A run sets degrees from the offsets, then per level scans and peels the queued vertices.
// Degree reads give 0 until a run has set them; offset and neighbor stores are undefined.
// rst_n is synchronous, active low; vertex_count resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module kcore_peeling_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operation[1:0], index[14:2], value[28:15]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // core_value[9:0]
  output logic             out_tuser   // result_kind
);
  logic [10:0] vcount_r;
  logic in_fire, busy, res_valid, res_kind;
  logic [9:0] res_value;
  logic [1:0] op;
  logic [12:0] idx;
  logic [13:0] val;
  kpe_pkg::kpe_cmd_t cmd;
  kpe_pkg::kpe_sts_t sts;

  assign op  = in_tdata[1:0];
  assign idx = in_tdata[14:2];
  assign val = in_tdata[28:15];
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 11'd1;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  kpe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(op), .in_idx(idx),
    .vcount(vcount_r), .out_free(out_tready), .busy(busy), .res_valid(res_valid),
    .res_kind(res_kind), .res_value(res_value), .cmd(cmd), .sts(sts));

  kpe_datapath u_dp (
    .clk(clk),
    .ld_ofs(in_fire && op == kpe_pkg::OP_LOAD_OFS && idx <= 13'(kpe_pkg::MaxVertices)),
    .ld_nbr(in_fire && op == kpe_pkg::OP_LOAD_NBR),
    .ld_idx(idx), .ld_val(val), .cmd(cmd), .sts(sts));

  assign out_tvalid = res_valid;
  assign out_tdata  = {6'd0, res_value};
  assign out_tuser  = res_kind;

  // A result only appears while the engine reports busy
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("result pending while accepting");
  // A result held under stall keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
endmodule
`default_nettype wire

[rtl/kpe_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module kpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/kpe_datapath.sv]
// Datapath: offset, neighbor, degree and queue memories.
`timescale 1ns / 1ps
`default_nettype none
module kpe_datapath (
  input  wire logic                 clk,
  input  wire logic                 ld_ofs,
  input  wire logic                 ld_nbr,
  input  wire logic [12:0]          ld_idx,
  input  wire logic [13:0]          ld_val,
  input  wire kpe_pkg::kpe_cmd_t    cmd,
  output kpe_pkg::kpe_sts_t         sts
);
  localparam int OfsDepth = kpe_pkg::MaxVertices + 1;
  localparam int OfsAW = $clog2(OfsDepth);

  logic [kpe_pkg::ValW-1:0] ofs_raw;
  logic [kpe_pkg::ValW-1:0] nbr_raw;
  logic [kpe_pkg::DW-1:0]   deg_raw;
  logic [kpe_pkg::VW-1:0]   que_raw;
  logic [OfsAW-1:0] ofs_waddr, ofs_raddr;

  assign ofs_waddr = OfsAW'(ld_idx);
  assign ofs_raddr = OfsAW'(cmd.ofs_addr);

  kpe_ram #(.Width(kpe_pkg::ValW), .Depth(OfsDepth)) u_ofs (
    .clk(clk), .we(ld_ofs), .waddr(ofs_waddr), .wdata(ld_val),
    .raddr(ofs_raddr), .rdata(ofs_raw));

  kpe_ram #(.Width(kpe_pkg::ValW), .Depth(kpe_pkg::MaxEdgeSlots)) u_nbr (
    .clk(clk), .we(ld_nbr), .waddr(ld_idx[kpe_pkg::EW-1:0]), .wdata(ld_val),
    .raddr(cmd.nbr_addr), .rdata(nbr_raw));

  kpe_ram #(.Width(kpe_pkg::DW), .Depth(kpe_pkg::MaxVertices)) u_deg (
    .clk(clk), .we(cmd.deg_wr), .waddr(cmd.deg_wr_addr), .wdata(cmd.deg_wr_data),
    .raddr(cmd.deg_addr), .rdata(deg_raw));

  kpe_ram #(.Width(kpe_pkg::VW), .Depth(kpe_pkg::MaxVertices)) u_que (
    .clk(clk), .we(cmd.q_wr), .waddr(cmd.q_wr_addr), .wdata(cmd.q_wr_data),
    .raddr(cmd.q_rd_addr), .rdata(que_raw));

  // Clamp offsets to the edge store size and pack the read data
  always_comb begin
    if (ofs_raw >= kpe_pkg::ValW'(kpe_pkg::MaxEdgeSlots)) begin
      sts.ofs_q = kpe_pkg::OW'(kpe_pkg::MaxEdgeSlots);
    end else begin
      sts.ofs_q = kpe_pkg::OW'(ofs_raw);
    end
    sts.nbr_q = nbr_raw;
    sts.deg_q = deg_raw;
    sts.q_q   = que_raw;
  end
endmodule
`default_nettype wire

[rtl/kpe_ctrl.sv]
// Controller: item decode and peeling sequencer.
`timescale 1ns / 1ps
`default_nettype none
module kpe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic [1:0]           in_op,
  input  wire logic [12:0]          in_idx,
  input  wire logic [10:0]          vcount,
  input  wire logic                 out_free,
  output logic                      busy,
  output logic                      res_valid,
  output logic                      res_kind,
  output logic [9:0]                res_value,
  output kpe_pkg::kpe_cmd_t         cmd,
  input  wire kpe_pkg::kpe_sts_t    sts
);
  localparam int VW = kpe_pkg::VW;
  localparam int CW = kpe_pkg::CW;
  localparam int OW = kpe_pkg::OW;
  localparam int DW = kpe_pkg::DW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ_D = 4'd1;  // read item: degree data back
  localparam logic [3:0] S_INIT   = 4'd2;  // degree init: read first offset
  localparam logic [3:0] S_INIT_S = 4'd3;
  localparam logic [3:0] S_INIT_E = 4'd4;  // one vertex per cycle
  localparam logic [3:0] S_SCAN   = 4'd5;  // scan degrees for level
  localparam logic [3:0] S_SCAN_W = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;  // read queue head
  localparam logic [3:0] S_POP_W  = 4'd8;
  localparam logic [3:0] S_OFS1   = 4'd9;
  localparam logic [3:0] S_OFS2   = 4'd10;
  localparam logic [3:0] S_EDGE   = 4'd11; // read neighbor
  localparam logic [3:0] S_NBR_W  = 4'd12;
  localparam logic [3:0] S_DEC    = 4'd13; // decrement neighbor degree
  localparam logic [3:0] S_LEVEL  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] nv_r, nv_nxt;
  logic [CW-1:0] fill_r, fill_nxt;    // degree entries below this were written by a run
  logic [CW-1:0] vi_r, vi_nxt;        // vertex cursor
  logic [OW-1:0] s_r, s_nxt;          // edge cursor
  logic [OW-1:0] e_r, e_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic [DW-1:0] level_r, level_nxt;
  logic [CW-1:0] proc_r, proc_nxt;
  logic [VW-1:0] u_r, u_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          rv_r, rv_nxt;
  logic          rk_r, rk_nxt;
  logic [DW-1:0] rval_r, rval_nxt;
  logic [CW-1:0] nv_cfg;
  logic [OW-1:0] init_dif;
  logic [DW-1:0] deg_dec;
  logic [CW:0]   proc_sum;

  assign busy      = (state_r != S_IDLE) || rv_r;
  assign res_valid = rv_r;
  assign res_kind  = rk_r;
  assign res_value = rval_r;
  assign nv_cfg    = (vcount > CW'(kpe_pkg::MaxVertices)) ? CW'(kpe_pkg::MaxVertices) : vcount;
  assign init_dif  = sts.ofs_q - s_r;
  assign deg_dec   = sts.deg_q - DW'(1);
  assign proc_sum  = {1'b0, proc_r} + {1'b0, tail_r};

  always_comb begin
    state_nxt = state_r; nv_nxt = nv_r; vi_nxt = vi_r; s_nxt = s_r; e_nxt = e_r;
    head_nxt = head_r; tail_nxt = tail_r; level_nxt = level_r; proc_nxt = proc_r;
    u_nxt = u_r; rd_ok_nxt = rd_ok_r; rv_nxt = rv_r; rk_nxt = rk_r; rval_nxt = rval_r;
    fill_nxt = fill_r;
    cmd = '0;
    if (rv_r && out_free) begin
      rv_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_op == kpe_pkg::OP_RUN) begin
          nv_nxt = nv_cfg;
          vi_nxt = '0;
          level_nxt = '0; proc_nxt = '0; head_nxt = '0; tail_nxt = '0;
          if (nv_cfg > fill_r) fill_nxt = nv_cfg;
          state_nxt = (nv_cfg == '0) ? S_DONE : S_INIT;
        end else if (in_fire && in_op == kpe_pkg::OP_READ) begin
          rd_ok_nxt = ({2'b0, nv_cfg} > in_idx) && ({2'b0, fill_r} > in_idx);
          cmd.deg_addr = in_idx[VW-1:0];
          state_nxt = S_READ_D;
        end
      end
      S_READ_D: begin
        rv_nxt = 1'b1; rk_nxt = kpe_pkg::KIND_CORE;
        rval_nxt = rd_ok_r ? sts.deg_q : '0;
        state_nxt = S_IDLE;
      end
      // Degree init: a vertex's end offset is the next vertex's start
      S_INIT: begin
        cmd.ofs_addr = '0;
        state_nxt = S_INIT_S;
      end
      S_INIT_S: begin
        s_nxt = sts.ofs_q;
        cmd.ofs_addr = (VW+1)'(1);
        state_nxt = S_INIT_E;
      end
      S_INIT_E: begin
        cmd.deg_wr = 1'b1;
        cmd.deg_wr_addr = vi_r[VW-1:0];
        if (sts.ofs_q <= s_r) cmd.deg_wr_data = '0;
        else if (init_dif > OW'(kpe_pkg::CoreLimit)) cmd.deg_wr_data = kpe_pkg::CoreLimit;
        else cmd.deg_wr_data = init_dif[DW-1:0];
        s_nxt = sts.ofs_q;
        if (vi_r + CW'(1) == nv_r) begin
          vi_nxt = '0; state_nxt = S_SCAN;
        end else begin
          vi_nxt = vi_r + CW'(1);
          cmd.ofs_addr = vi_r + CW'(2);
        end
      end
      // Level scan: push each vertex with degree == level
      S_SCAN: begin
        cmd.deg_addr = vi_r[VW-1:0];
        state_nxt = S_SCAN_W;
      end
      S_SCAN_W: begin
        if (sts.deg_q == level_r && tail_r < CW'(kpe_pkg::MaxVertices)) begin
          cmd.q_wr = 1'b1;
          cmd.q_wr_addr = tail_r[VW-1:0];
          cmd.q_wr_data = vi_r[VW-1:0];
          tail_nxt = tail_r + CW'(1);
        end
        if (vi_r + CW'(1) == nv_r) begin
          vi_nxt = '0; state_nxt = S_POP;
        end else begin
          vi_nxt = vi_r + CW'(1); state_nxt = S_SCAN;
        end
      end
      S_POP: begin
        if (head_r < tail_r) begin
          cmd.q_rd_addr = head_r[VW-1:0];
          head_nxt = head_r + CW'(1);
          state_nxt = S_POP_W;
        end else begin
          state_nxt = S_LEVEL;
        end
      end
      S_POP_W: begin
        u_nxt = sts.q_q;
        cmd.ofs_addr = {1'b0, sts.q_q};
        state_nxt = S_OFS1;
      end
      S_OFS1: begin
        cmd.ofs_addr = {1'b0, u_r} + (VW+1)'(1);
        s_nxt = sts.ofs_q;
        state_nxt = S_OFS2;
      end
      S_OFS2: begin
        e_nxt = sts.ofs_q;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (s_r < e_r) begin
          cmd.nbr_addr = s_r[kpe_pkg::EW-1:0];
          s_nxt = s_r + OW'(1);
          state_nxt = S_NBR_W;
        end else begin
          state_nxt = S_POP;
        end
      end
      // Out-of-range neighbor ids are skipped
      S_NBR_W: begin
        if (sts.nbr_q >= {3'b0, nv_r}) begin
          state_nxt = S_EDGE;
        end else begin
          u_nxt = sts.nbr_q[VW-1:0];
          cmd.deg_addr = sts.nbr_q[VW-1:0];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.deg_q > level_r) begin
          cmd.deg_wr = 1'b1;
          cmd.deg_wr_addr = u_r;
          cmd.deg_wr_data = deg_dec;
          if (deg_dec == level_r && tail_r < CW'(kpe_pkg::MaxVertices)) begin
            cmd.q_wr = 1'b1;
            cmd.q_wr_addr = tail_r[VW-1:0];
            cmd.q_wr_data = u_r;
            tail_nxt = tail_r + CW'(1);
          end
        end
        state_nxt = S_EDGE;
      end
      S_LEVEL: begin
        proc_nxt = proc_sum[CW-1:0];
        if (proc_sum >= (CW+1)'(nv_r) || level_r == kpe_pkg::CoreLimit) begin
          state_nxt = S_DONE;
        end else begin
          level_nxt = level_r + DW'(1);
          head_nxt = '0; tail_nxt = '0; vi_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        rv_nxt = 1'b1; rk_nxt = kpe_pkg::KIND_RUN; rval_nxt = level_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rv_r <= 1'b0; fill_r <= '0;
      head_r <= '0; tail_r <= '0; level_r <= '0; proc_r <= '0;
    end else begin
      state_r <= state_nxt; rv_r <= rv_nxt; fill_r <= fill_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; level_r <= level_nxt; proc_r <= proc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nv_r <= nv_nxt; vi_r <= vi_nxt; s_r <= s_nxt; e_r <= e_nxt; u_r <= u_nxt;
    rd_ok_r <= rd_ok_nxt; rk_r <= rk_nxt; rval_r <= rval_nxt;
  end
endmodule
`default_nettype wire

[dv/kcore_peeling_engine_top_test.sv]
// Self-checking testbench for the k-core peeling engine: random CSR graphs, runs and reads.
`timescale 1ns / 1ps
module kcore_peeling_engine_top_test;
  localparam int CycleLimit = 3000000;
  localparam int LongHold   = 400;
  localparam int ItemTarget = 1550;

  typedef struct packed {
    logic [kpe_pkg::OpW-1:0]  op;
    logic [kpe_pkg::IdxW-1:0] idx;
    logic [kpe_pkg::ValW-1:0] val;
  } graph_item_t;

  typedef struct packed {
    logic                   kind;
    logic [kpe_pkg::DW-1:0] core;
  } core_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // operation[1:0], index[14:2], value[28:15]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // core_value[9:0]
  logic        out_tuser;       // result_kind

  kcore_peeling_engine_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Shadow copy of the engine state
  int ofs_mem [0:kpe_pkg::MaxVertices];
  int nbr_mem [0:kpe_pkg::MaxEdgeSlots-1];
  int deg_mem [0:kpe_pkg::MaxVertices-1];
  int shadow_vcount = 1;

  graph_item_t  pending_items[$];
  core_answer_t core_answers[$];
  int           gen_ofs [0:kpe_pkg::MaxVertices];

  int  errors = 0;
  int  issued = 0;
  bit  idle_on = 1'b1;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  gap_cnt = 0;
  int  stall_cnt = 0;
  int  cycles = 0;

  function automatic int clamp_ofs(int v);
    return ofs_mem[v] < kpe_pkg::MaxEdgeSlots ? ofs_mem[v] : kpe_pkg::MaxEdgeSlots;
  endfunction

  // Level-by-level peeling; leaves core numbers in deg_mem, returns max core
  function automatic int peel_graph(int nv);
    int v, s, e, lvl, done, head, tail, w, j, u;
    int frontier [0:kpe_pkg::MaxVertices-1];
    for (v = 0; v < nv; v++) begin
      s = clamp_ofs(v);
      e = clamp_ofs(v + 1);
      e = e > s ? e - s : 0;
      deg_mem[v] = e > kpe_pkg::CoreLimit ? kpe_pkg::CoreLimit : e;
    end
    if (nv == 0) return 0;
    lvl = 0;
    done = 0;
    forever begin
      head = 0;
      tail = 0;
      for (v = 0; v < nv; v++)
        if (deg_mem[v] == lvl && tail < kpe_pkg::MaxVertices) begin
          frontier[tail] = v;
          tail++;
        end
      while (head < tail) begin
        w = frontier[head];
        head++;
        s = clamp_ofs(w);
        e = clamp_ofs(w + 1);
        for (j = s; j < e; j++) begin
          u = nbr_mem[j];
          if (u < nv && deg_mem[u] > lvl) begin
            deg_mem[u]--;
            if (deg_mem[u] == lvl && tail < kpe_pkg::MaxVertices) begin
              frontier[tail] = u;
              tail++;
            end
          end
        end
      end
      done += tail;
      if (done >= nv || lvl >= kpe_pkg::CoreLimit) break;
      lvl++;
    end
    return lvl;
  endfunction

  // Update the shadow state for one accepted item and queue its answer
  task automatic apply_item(graph_item_t it);
    int nv;
    core_answer_t ans;
    nv = shadow_vcount < kpe_pkg::MaxVertices ? shadow_vcount : kpe_pkg::MaxVertices;
    case (it.op)
      kpe_pkg::OP_LOAD_OFS: if (it.idx <= kpe_pkg::MaxVertices) ofs_mem[it.idx] = it.val;
      kpe_pkg::OP_LOAD_NBR: nbr_mem[it.idx] = it.val;
      kpe_pkg::OP_RUN: begin
        ans.kind = kpe_pkg::KIND_RUN;
        ans.core = kpe_pkg::DW'(peel_graph(nv));
        core_answers.push_back(ans);
      end
      default: begin
        ans.kind = kpe_pkg::KIND_CORE;
        ans.core = it.idx < nv ? kpe_pkg::DW'(deg_mem[it.idx]) : '0;
        core_answers.push_back(ans);
      end
    endcase
  endtask

  // Input driver
  always @(posedge clk) begin
    bit nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_item(pending_items.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_cnt = $urandom_range(0, 8);
        end else if (pending_items.size() > 0) begin
          nxt_valid = 1'b1;
          in_tdata <= {3'b0, pending_items[0].val, pending_items[0].idx, pending_items[0].op};
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // Result ready: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt = LongHold;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    core_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (core_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected item kind=%0b core=%0d", $time, out_tuser, out_tdata[9:0]);
      end else begin
        want = core_answers.pop_front();
        if (out_tuser !== want.kind) begin
          errors++;
          $display("%0t: result_kind expected %0b actual %0b", $time, want.kind, out_tuser);
        end
        if (out_tdata[9:0] !== want.core) begin
          errors++;
          $display("%0t: core_value expected %0d actual %0d", $time, want.core,
                   out_tdata[9:0]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("kcore_peeling_engine_top_test: FAIL");
      $finish;
    end
  end

  task automatic send(logic [kpe_pkg::OpW-1:0] op, int idx, int val);
    graph_item_t it;
    it.op = op;
    it.idx = kpe_pkg::IdxW'(idx);
    it.val = kpe_pkg::ValW'(val);
    pending_items.push_back(it);
    issued++;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || core_answers.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_vcount(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 11'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_vcount = v;
    @(negedge clk);
  endtask

  // Random CSR graph over vertices 0..nv-1, edges starting at slot base
  task automatic load_graph(int nv, int base, int max_deg, int sparse_pct);
    int v, s;
    gen_ofs[0] = base;
    for (v = 0; v < nv; v++) begin
      if ($urandom_range(0, 99) < 8 && gen_ofs[v] > base)
        gen_ofs[v + 1] = gen_ofs[v] - $urandom_range(1, gen_ofs[v] - base);
      else if ($urandom_range(0, 99) < sparse_pct)
        gen_ofs[v + 1] = gen_ofs[v];
      else
        gen_ofs[v + 1] = gen_ofs[v] + $urandom_range(0, max_deg);
    end
    for (v = 0; v <= nv; v++) begin
      send(kpe_pkg::OP_LOAD_OFS, v, gen_ofs[v]);
      // ignored loads past the offset store
      if ($urandom_range(0, 30) == 0) send(kpe_pkg::OP_LOAD_OFS, $urandom_range(1025, 8191),
                                           $urandom_range(0, 16383));
    end
    for (v = 0; v < nv; v++)
      for (s = gen_ofs[v]; s < gen_ofs[v + 1]; s++)
        send(kpe_pkg::OP_LOAD_NBR, s, $urandom_range(0, 99) < 85 ? $urandom_range(0, nv - 1)
                                                                  : $urandom_range(0, 16383));
  endtask

  task automatic read_all(int nv);
    int v;
    for (v = 0; v < nv; v++) send(kpe_pkg::OP_READ, v, $urandom_range(0, 16383));
    send(kpe_pkg::OP_READ, $urandom_range(0, 8191), 0);
    send(kpe_pkg::OP_READ, 8191, 0);
  endtask

  initial begin
    int nv, s, k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reads before any run, self loop, duplicate, invalid id, falling offset
    send(kpe_pkg::OP_READ, 0, 16383);
    send(kpe_pkg::OP_READ, 8191, 0);
    drain();
    write_vcount(4);
    send(kpe_pkg::OP_LOAD_OFS, 0, 0);
    send(kpe_pkg::OP_LOAD_OFS, 1, 3);
    send(kpe_pkg::OP_LOAD_OFS, 2, 5);
    send(kpe_pkg::OP_LOAD_OFS, 3, 2);
    send(kpe_pkg::OP_LOAD_OFS, 4, 4);
    send(kpe_pkg::OP_LOAD_OFS, 8191, 16383);
    send(kpe_pkg::OP_LOAD_NBR, 0, 0);
    send(kpe_pkg::OP_LOAD_NBR, 1, 1);
    send(kpe_pkg::OP_LOAD_NBR, 2, 1);
    send(kpe_pkg::OP_LOAD_NBR, 3, 0);
    send(kpe_pkg::OP_LOAD_NBR, 4, 16383);
    send(kpe_pkg::OP_RUN, 8191, 16383);
    read_all(5);
    drain();
    write_vcount(0);
    send(kpe_pkg::OP_RUN, 0, 0);
    send(kpe_pkg::OP_READ, 0, 0);
    drain();

    // Degree above the saturation limit, offsets past the edge store
    write_vcount(4);
    send(kpe_pkg::OP_LOAD_OFS, 0, 7160);
    send(kpe_pkg::OP_LOAD_OFS, 1, 16383);
    send(kpe_pkg::OP_LOAD_OFS, 2, 100);
    send(kpe_pkg::OP_LOAD_OFS, 3, 100);
    send(kpe_pkg::OP_LOAD_OFS, 4, 103);
    for (s = 7160; s < kpe_pkg::MaxEdgeSlots; s++)
      send(kpe_pkg::OP_LOAD_NBR, s, $urandom_range(0, 9) < 8 ? $urandom_range(0, 3)
                                                             : $urandom_range(0, 16383));
    for (s = 100; s < 103; s++) send(kpe_pkg::OP_LOAD_NBR, s, $urandom_range(0, 3));
    send(kpe_pkg::OP_RUN, 0, 0);
    read_all(4);
    drain();

    // Random phases of small graphs
    k = 0;
    while (issued < ItemTarget - 60) begin
      idle_on = $urandom_range(0, 3) != 0;
      nv = $urandom_range(1, 20);
      write_vcount(nv);
      if ($urandom_range(0, 1)) send(kpe_pkg::OP_READ, $urandom_range(0, nv - 1), 0);
      load_graph(nv, $urandom_range(0, 4000), $urandom_range(1, 6), 10);
      send(kpe_pkg::OP_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383));
      if (k == 1) begin
        // receiver holds off while reads keep coming
        hold_seq++;
        read_all(nv);
        read_all(nv);
      end else begin
        read_all(nv);
      end
      if ($urandom_range(0, 3) == 0) send(kpe_pkg::OP_RUN, 0, 0);
      drain();
      k++;
    end

    // Last part: no idling on either side
    idle_on = 1'b0;
    write_vcount(12);
    load_graph(12, 0, 5, 0);
    send(kpe_pkg::OP_RUN, 0, 0);
    read_all(12);
    drain();

    if (errors == 0)
      $display("kcore_peeling_engine_top_test: PASS");
    else
      $display("kcore_peeling_engine_top_test: FAIL");
    $finish;
  end
endmodule
